[rtl/tun_pkg.sv]
`default_nettype none
package tun_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;

  // sideband that rides with each lane through the long arithmetic pipes
  typedef struct packed {
    logic deg;
    logic neg;
  } tag_t;

endpackage
`default_nettype wire

[rtl/tun_cross.sv]
`default_nettype none
module tun_cross #(
  parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF,
  parameter int SQ_W        = 4 * COORD_WIDTH + 4,
  parameter int SUM_W       = SQ_W + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] v0_x,
  input  wire logic signed [COORD_WIDTH-1:0] v0_y,
  input  wire logic signed [COORD_WIDTH-1:0] v0_z,
  input  wire logic signed [COORD_WIDTH-1:0] v1_x,
  input  wire logic signed [COORD_WIDTH-1:0] v1_y,
  input  wire logic signed [COORD_WIDTH-1:0] v1_z,
  input  wire logic signed [COORD_WIDTH-1:0] v2_x,
  input  wire logic signed [COORD_WIDTH-1:0] v2_y,
  input  wire logic signed [COORD_WIDTH-1:0] v2_z,
  output logic                               out_valid,
  output logic [SQ_W-1:0]                    sq [3],
  output logic [SUM_W-1:0]                   sum,
  output tun_pkg::tag_t                      tag [3]
);
  import tun_pkg::*;

  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int CXW = PW + 1;
  localparam int MW  = CXW - 1;

  logic                 v1, v2, v3, v4;
  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] p [6];
  logic signed [CXW-1:0] cv [3];
  logic [MW-1:0]        cm [3];
  logic                 neg3 [3];
  logic [SQ_W-1:0]      sq4 [3];
  logic                 neg4 [3];
  logic                 deg5;
  logic                 neg5 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_comb begin
    cv[0] = CXW'(p[0]) - CXW'(p[1]);
    cv[1] = CXW'(p[2]) - CXW'(p[3]);
    cv[2] = CXW'(p[4]) - CXW'(p[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= EW'(v1_x) - EW'(v0_x);
      ay <= EW'(v1_y) - EW'(v0_y);
      az <= EW'(v1_z) - EW'(v0_z);
      bx <= EW'(v2_x) - EW'(v0_x);
      by <= EW'(v2_y) - EW'(v0_y);
      bz <= EW'(v2_z) - EW'(v0_z);
      p[0] <= PW'(ay) * PW'(bz);
      p[1] <= PW'(by) * PW'(az);
      p[2] <= PW'(bx) * PW'(az);
      p[3] <= PW'(ax) * PW'(bz);
      p[4] <= PW'(ax) * PW'(by);
      p[5] <= PW'(bx) * PW'(ay);
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= cv[i][CXW-1];
        cm[i]   <= cv[i][CXW-1] ? MW'(-cv[i]) : MW'(cv[i]);
        sq4[i]  <= SQ_W'(cm[i]) * SQ_W'(cm[i]);
        neg4[i] <= neg3[i];
        sq[i]   <= sq4[i];
        neg5[i] <= neg4[i];
      end
      sum  <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
      deg5 <= (sq4[0] == '0) && (sq4[1] == '0) && (sq4[2] == '0);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tag[i].deg = deg5;
      tag[i].neg = neg5[i];
    end
  end

endmodule
`default_nettype wire

[rtl/tun_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per stage: quo = floor(num * 2^(QUO_W-1) / den),
// valid when num <= den.
module tun_divider #(
  parameter int NUM_W = 68,
  parameter int DEN_W = 70,
  parameter int QUO_W = 31
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  input  wire tun_pkg::tag_t      tag_in,
  output logic                    out_valid,
  output logic [QUO_W-1:0]        quo,
  output tun_pkg::tag_t           tag_out
);
  import tun_pkg::*;

  logic             val [QUO_W];
  logic [DEN_W:0]   rem [QUO_W];
  logic [DEN_W-1:0] dv  [QUO_W];
  logic [QUO_W-1:0] q   [QUO_W];
  tag_t             tg  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W:0]   r;
    logic [DEN_W-1:0] d;
    logic [QUO_W-1:0] qp;
    logic             vp;
    tag_t             tp;
    logic             ge;
    if (i == 0) begin : g_first
      assign r  = (DEN_W + 1)'(num);
      assign d  = den;
      assign qp = '0;
      assign vp = in_valid;
      assign tp = tag_in;
    end else begin : g_next
      // remainder stays below den, so the shift cannot overflow
      assign r  = {rem[i-1][DEN_W-1:0], 1'b0};
      assign d  = dv[i-1];
      assign qp = q[i-1];
      assign vp = val[i-1];
      assign tp = tg[i-1];
    end
    assign ge = r >= {1'b0, d};

    always_ff @(posedge clk) begin
      if (rst) begin
        val[i] <= 1'b0;
      end else if (en) begin
        val[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? r - {1'b0, d} : r;
        dv[i]  <= d;
        q[i]   <= {qp[QUO_W-2:0], ge};
        tg[i]  <= tp;
      end
    end
  end

  assign out_valid = val[QUO_W-1];
  assign quo       = q[QUO_W-1];
  assign tag_out   = tg[QUO_W-1];

endmodule
`default_nettype wire

[rtl/tun_sqrt.sv]
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
module tun_sqrt #(
  parameter int IN_W   = 31,
  parameter int ROOT_W = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [IN_W-1:0]   rad,
  input  wire tun_pkg::tag_t     tag_in,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      root,
  output tun_pkg::tag_t          tag_out
);
  import tun_pkg::*;

  localparam int TW = 2 * ROOT_W + 1;

  logic              val [ROOT_W];
  logic [TW-1:0]     rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];
  tag_t              tg  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int J = ROOT_W - 1 - s;
    logic [TW-1:0]     rp;
    logic [ROOT_W-1:0] tp_root;
    logic              vp;
    tag_t              tp;
    logic [TW-1:0]     trial;
    logic              ge;
    if (s == 0) begin : g_first
      assign rp      = TW'(rad);
      assign tp_root = '0;
      assign vp      = in_valid;
      assign tp      = tag_in;
    end else begin : g_next
      assign rp      = rem[s-1];
      assign tp_root = rt[s-1];
      assign vp      = val[s-1];
      assign tp      = tg[s-1];
    end
    // (root + 2^J)^2 - root^2 = root * 2^(J+1) + 2^(2J)
    assign trial = (TW'(tp_root) << (J + 1)) + (TW'(1) << (2 * J));
    assign ge    = rp >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        val[s] <= 1'b0;
      end else if (en) begin
        val[s] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? rp - trial : rp;
        rt[s]  <= ge ? (tp_root | (ROOT_W'(1) << J)) : tp_root;
        tg[s]  <= tp;
      end
    end
  end

  assign out_valid = val[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign tag_out   = tg[ROOT_W-1];

endmodule
`default_nettype wire

[rtl/triangle_unit_normal.sv]
`default_nettype none
// Unit face normal of a triangle. One triangle is accepted every cycle unless the
// output is stalled, and each gives exactly one result, in order: five stages form the
// edges, the exact cross product and its squared length, a restoring divider takes one
// quotient bit per stage (2*OUT_FRAC_BITS + 3), a square root takes one root bit per
// stage (OUT_FRAC_BITS + 2), and one output register rounds and applies the sign. The
// whole pipe holds while a result waits untaken. Each component is
// round-half-away(|c_i| * 2^F / |c|) with the sign of c_i; a zero cross product raises
// degenerate and gives a zero normal.
module triangle_unit_normal #(
  parameter int COORD_WIDTH   = tun_pkg::COORD_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] v0_x,
  input  wire logic signed [COORD_WIDTH-1:0] v0_y,
  input  wire logic signed [COORD_WIDTH-1:0] v0_z,
  input  wire logic signed [COORD_WIDTH-1:0] v1_x,
  input  wire logic signed [COORD_WIDTH-1:0] v1_y,
  input  wire logic signed [COORD_WIDTH-1:0] v1_z,
  input  wire logic signed [COORD_WIDTH-1:0] v2_x,
  input  wire logic signed [COORD_WIDTH-1:0] v2_y,
  input  wire logic signed [COORD_WIDTH-1:0] v2_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [OUT_FRAC_BITS+1:0]    norm_x,
  output logic signed [OUT_FRAC_BITS+1:0]    norm_y,
  output logic signed [OUT_FRAC_BITS+1:0]    norm_z,
  output logic                               degenerate
);
  import tun_pkg::*;

  localparam int SQ_W   = 4 * COORD_WIDTH + 4;
  localparam int SUM_W  = SQ_W + 2;
  localparam int QUO_W  = 2 * OUT_FRAC_BITS + 3;
  localparam int ROOT_W = OUT_FRAC_BITS + 2;
  localparam int OW     = OUT_FRAC_BITS + 2;

  logic              en;
  logic              cr_valid;
  logic [SQ_W-1:0]   sq [3];
  logic [SUM_W-1:0]  sum;
  tag_t              cr_tag [3];
  logic              dv_valid [3];
  logic [QUO_W-1:0]  quo [3];
  tag_t              dv_tag [3];
  logic              sr_valid [3];
  logic [ROOT_W-1:0] root [3];
  tag_t              sr_tag [3];
  logic [OW-1:0]     mag [3];
  logic [OW-1:0]     res [3];

  // advance everything unless a result is held at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tun_cross #(
    .COORD_WIDTH (COORD_WIDTH),
    .SQ_W        (SQ_W),
    .SUM_W       (SUM_W)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .v0_x      (v0_x),
    .v0_y      (v0_y),
    .v0_z      (v0_z),
    .v1_x      (v1_x),
    .v1_y      (v1_y),
    .v1_z      (v1_z),
    .v2_x      (v2_x),
    .v2_y      (v2_y),
    .v2_z      (v2_z),
    .out_valid (cr_valid),
    .sq        (sq),
    .sum       (sum),
    .tag       (cr_tag)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tun_divider #(
      .NUM_W (SQ_W),
      .DEN_W (SUM_W),
      .QUO_W (QUO_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cr_valid),
      .num       (sq[i]),
      .den       (sum),
      .tag_in    (cr_tag[i]),
      .out_valid (dv_valid[i]),
      .quo       (quo[i]),
      .tag_out   (dv_tag[i])
    );

    tun_sqrt #(
      .IN_W   (QUO_W),
      .ROOT_W (ROOT_W)
    ) u_sqrt (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[i]),
      .rad       (quo[i]),
      .tag_in    (dv_tag[i]),
      .out_valid (sr_valid[i]),
      .root      (root[i]),
      .tag_out   (sr_tag[i])
    );

    // largest m with (2m-1) <= isqrt(q) is (isqrt(q)+1)/2
    assign mag[i] = OW'(((ROOT_W + 1)'(root[i]) + (ROOT_W + 1)'(1)) >> 1);
    assign res[i] = sr_tag[i].deg ? '0 : (sr_tag[i].neg ? -mag[i] : mag[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sr_valid[0] && sr_valid[1] && sr_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_x     <= res[0];
      norm_y     <= res[1];
      norm_z     <= res[2];
      degenerate <= sr_tag[0].deg;
    end
  end

endmodule
`default_nettype wire

[rtl/tun_checker.sv]
`default_nettype none
module tun_checker #(
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic signed [OUT_FRAC_BITS+1:0] norm_x,
  input wire logic signed [OUT_FRAC_BITS+1:0] norm_y,
  input wire logic signed [OUT_FRAC_BITS+1:0] norm_z,
  input wire logic                            degenerate
);
  localparam logic signed [OUT_FRAC_BITS+1:0] ONE  = (OUT_FRAC_BITS + 2)'(1) << OUT_FRAC_BITS;
  localparam logic signed [OUT_FRAC_BITS+1:0] MONE = -ONE;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({norm_x, norm_y, norm_z, degenerate}))
    else $error("stalled result changed");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == 0 && norm_y == 0 && norm_z == 0)
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_x <= ONE && norm_x >= MONE && norm_y <= ONE && norm_y >= MONE
                  && norm_z <= ONE && norm_z >= MONE)
    else $error("normal component out of unit range");

endmodule

bind triangle_unit_normal tun_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_tun_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .norm_x     (norm_x),
  .norm_y     (norm_y),
  .norm_z     (norm_z),
  .degenerate (degenerate)
);
`default_nettype wire

[tb/triangle_unit_normal_test.sv]
module triangle_unit_normal_test;

  typedef struct {
    logic signed [15:0] c[9];  // v0 xyz, v1 xyz, v2 xyz
    bit                 sync;  // marker: hold off until every normal has come back
  } tri_t;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               deg;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] v0_x = '0, v0_y = '0, v0_z = '0;
  logic signed [15:0] v1_x = '0, v1_y = '0, v1_z = '0;
  logic signed [15:0] v2_x = '0, v2_y = '0, v2_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic degenerate;

  triangle_unit_normal uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tri_t    pending_tris[$];
  normal_t expected_normals[$];
  tri_t    cur_tri;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      hold_left = 0;
  bit      hold_done = 0;
  int      normals_seen = 0;
  int      mismatches = 0;
  int      cycles = 0;
  bit      send_lazy = 1, recv_lazy = 1;

  // round(|c| * 2^14 / len) by bisection on the squared inequality, sign applied
  function automatic logic signed [15:0] unit_comp(logic [127:0] mag, logic [127:0] sumsq,
                                                   bit neg);
    logic [127:0] rhs, t, lhs;
    int lo, hi, mid;
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = 1 << 14;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 128'(2 * mid - 1);
      lhs = t * t * sumsq;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return neg ? -16'(lo) : 16'(lo);
  endfunction

  function automatic normal_t face_normal(tri_t t);
    logic signed [17:0] ax, ay, az, bx, by, bz;
    logic signed [37:0] cr[3];
    logic [127:0] mag[3], sumsq;
    normal_t n;
    ax = t.c[3] - t.c[0]; ay = t.c[4] - t.c[1]; az = t.c[5] - t.c[2];
    bx = t.c[6] - t.c[0]; by = t.c[7] - t.c[1]; bz = t.c[8] - t.c[2];
    cr[0] = ay * bz - by * az;
    cr[1] = bx * az - ax * bz;
    cr[2] = ax * by - bx * ay;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 128'(-cr[i]) : 128'(cr[i]);
      sumsq += mag[i] * mag[i];
    end
    if (sumsq == 0) begin
      n.nx = '0; n.ny = '0; n.nz = '0; n.deg = 1'b1;
    end else begin
      n.nx = unit_comp(mag[0], sumsq, cr[0] < 0);
      n.ny = unit_comp(mag[1], sumsq, cr[1] < 0);
      n.nz = unit_comp(mag[2], sumsq, cr[2] < 0);
      n.deg = 1'b0;
    end
    return n;
  endfunction

  function automatic logic signed [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16)) - 16'sd8;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom) >>> $urandom_range(0, 15);
    endcase
  endfunction

  task automatic add_tri(input int a, b, c, d, e, f, g, h, k);
    tri_t t;
    t.c = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h), 16'(k)};
    t.sync = 0;
    pending_tris = {pending_tris, t};
  endtask

  task automatic add_sync();
    tri_t t;
    t.c = '{default: '0};
    t.sync = 1;
    pending_tris = {pending_tris, t};
  endtask

  initial begin
    tri_t t;
    int m, d[3];
    // directed corners
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);                        // coincident
    add_tri(100, 200, 300, 100, 200, 300, 5, 6, 7);            // two equal vertices
    add_tri(0, 0, 0, 10, 20, 30, 20, 40, 60);                  // collinear
    add_tri(0, 0, 0, 16384, 0, 0, 0, 16384, 0);                // +z
    add_tri(0, 0, 0, 0, 16384, 0, 16384, 0, 0);                // -z
    add_tri(0, 0, 0, 0, 16384, 0, 0, 0, 16384);                // +x
    add_tri(0, 0, 0, 0, 0, 16384, 16384, 0, 0);                // +y
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);                        // smallest
    add_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
    add_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
    add_tri(-32768, -32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767);
    add_tri(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
    add_tri(0, 0, 0, 16384, 16384, 16384, 16384, -16384, 0);
    add_tri(0, 0, 0, 1, 1, 0, 1, 0, 1);
    add_tri(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
    add_tri(-32768, 0, 32767, 32767, 0, -32768, 0, 32767, 0);
    add_sync();
    for (int n = 0; n < 800; n++) begin
      if (n == 400) add_sync();
      m = $urandom_range(0, 9);
      if (m == 9) begin
        // collinear: v2 = v0 + 2*(v1 - v0)
        for (int i = 0; i < 3; i++) begin
          d[i] = $urandom_range(0, 4000) - 2000;
          t.c[i] = 16'($urandom_range(0, 20000) - 10000);
          t.c[i + 3] = t.c[i] + 16'(d[i]);
          t.c[i + 6] = t.c[i] + 16'(2 * d[i]);
        end
      end else begin
        for (int i = 0; i < 9; i++) t.c[i] = rnd_coord(m < 5 ? 0 : m - 5);
      end
      t.sync = 0;
      pending_tris = {pending_tris, t};
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_tris.size() == 0 && !in_valid && expected_normals.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_normals.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    bit nv;
    nv = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_normals = {expected_normals, face_normal(cur_tri)};
        nv = 0;
        if ($urandom_range(0, 99) == 0) send_lazy = !send_lazy;
        send_gap = send_lazy ? $urandom_range(0, 6) : 0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_tris.size() > 0) begin
          if (pending_tris[0].sync) begin
            // drain: drop the marker once nothing is outstanding
            if (expected_normals.size() == 0) void'(pending_tris.pop_front());
          end else begin
            cur_tri = pending_tris.pop_front();
            {v0_x, v0_y, v0_z} <= {cur_tri.c[0], cur_tri.c[1], cur_tri.c[2]};
            {v1_x, v1_y, v1_z} <= {cur_tri.c[3], cur_tri.c[4], cur_tri.c[5]};
            {v2_x, v2_y, v2_z} <= {cur_tri.c[6], cur_tri.c[7], cur_tri.c[8]};
            nv = 1;
          end
        end
      end
    end
    in_valid <= nv;
  end

  // long receiver hold-off so the pipe backs up into the input
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (!hold_done && normals_seen >= 300) begin
      hold_left <= 300;
      hold_done <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    normal_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        normals_seen++;
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %0d %0d %0d deg %0d",
                                         norm_x, norm_y, norm_z, degenerate);
        end else begin
          e = expected_normals.pop_front();
          if (norm_x !== e.nx || norm_y !== e.ny || norm_z !== e.nz
              || degenerate !== e.deg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0d deg %0d, got %0d %0d %0d deg %0d",
                       e.nx, e.ny, e.nz, e.deg, norm_x, norm_y, norm_z, degenerate);
          end
        end
        if ($urandom_range(0, 99) == 0) recv_lazy = !recv_lazy;
        recv_gap = recv_lazy ? $urandom_range(0, 6) : 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
    end
    out_ready <= !rst && recv_gap == 0 && hold_left == 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
